// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define NNT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define NNT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define NNT_ASSERT(lbl, prop, msg)
`define NNT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- design/nnt_pkg.sv -----
// ----------------------------------------------------------------------------
// nnt_pkg
// Shared constants and types for the nearest-neighbour tour block.
// ----------------------------------------------------------------------------
package nnt_pkg;
	localparam int MAX_CITIES_DEF = 64;
	localparam int COORD_BITS_DEF = 20;
	localparam int LABEL_W = 16;
	localparam int POS_W = 6;

	// per-cycle controls broadcast to every cell
	typedef struct packed {
		logic wr_en;    // store a city at the load pointer
		logic mark_en;  // flag the selected city as visited
		logic clr;      // end of set: drop loaded/visited flags
	} cell_ctrl_t;
endpackage

// ----- design/nearest_neighbor_tour_top.sv -----
// ----------------------------------------------------------------------------
// nearest_neighbor_tour_top
// Greedy nearest-neighbour tour over up to MAX_CITIES loaded cities.
// ----------------------------------------------------------------------------
// Channel | Handshake              | Payload
// city    | city_valid/city_ready  | city_label, coord_x, coord_y, last_city
// tour    | tour_valid/tour_ready  | tour_label, tour_position, tour_end, overflow
//
// Loading accepts one city per cycle while city_ready is high. After the
// last city each tour position runs three distance stages in every cell,
// then the best candidate ripples down the cell chain one cell a cycle.
// A stalled tour output holds the next selection back. city_ready is low
// from the last city until the final position is in the output register.
// Reset leaves no cities loaded.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nearest_neighbor_tour_top #(
	parameter int MAX_CITIES = nnt_pkg::MAX_CITIES_DEF,
	parameter int COORD_BITS = nnt_pkg::COORD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic city_valid,
	output logic city_ready,
	input  logic [nnt_pkg::LABEL_W-1:0] city_label,
	input  logic signed [COORD_BITS-1:0] coord_x,
	input  logic signed [COORD_BITS-1:0] coord_y,
	input  logic last_city,
	output logic tour_valid,
	input  logic tour_ready,
	output logic [nnt_pkg::LABEL_W-1:0] tour_label,
	output logic [nnt_pkg::POS_W-1:0] tour_position,
	output logic tour_end,
	output logic overflow
);
	import nnt_pkg::*;

	localparam int IDX_W = $clog2(MAX_CITIES);
	localparam int CNT_W = $clog2(MAX_CITIES + 1);
	localparam int DIST_W = 2 * (COORD_BITS + 1) + 1;
	localparam int WAIT_CYC = MAX_CITIES + 4;
	localparam int WAIT_W = $clog2(WAIT_CYC + 1);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_CITIES);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0] state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] pos_q;
	logic [WAIT_W-1:0] wait_q;
	logic dropped_q;
	logic signed [COORD_BITS-1:0] first_x_q, first_y_q, cur_x_q, cur_y_q;
	logic out_valid_q, out_end_q, out_ovf_q;
	logic [LABEL_W-1:0] out_label_q;
	logic [CNT_W-1:0] out_pos_q;

	cell_ctrl_t ctrl;
	logic accept, full, emit, final_pos;

	logic ch_valid [MAX_CITIES+1];
	logic [DIST_W-1:0] ch_dist [MAX_CITIES+1];
	logic [IDX_W-1:0] ch_idx [MAX_CITIES+1];
	logic [LABEL_W-1:0] ch_label [MAX_CITIES+1];
	logic signed [COORD_BITS-1:0] ch_x [MAX_CITIES+1];
	logic signed [COORD_BITS-1:0] ch_y [MAX_CITIES+1];

	assign city_ready = (state_q == ST_IDLE);
	assign accept = city_valid && city_ready;
	assign full = (count_q == FULL);
	assign emit = (state_q == ST_EMIT) && (!out_valid_q || tour_ready);
	assign final_pos = ((pos_q + CNT_W'(1)) == count_q);

	assign ctrl.wr_en = accept && !full;
	assign ctrl.mark_en = emit;
	assign ctrl.clr = emit && final_pos;

	assign ch_valid[0] = 1'b0;
	assign ch_dist[0] = '0;
	assign ch_idx[0] = '0;
	assign ch_label[0] = '0;
	assign ch_x[0] = '0;
	assign ch_y[0] = '0;

	for (genvar g = 0; g < MAX_CITIES; g++) begin : g_cell
		nnt_cell #(
			.COORD_BITS(COORD_BITS),
			.IDX_W(IDX_W),
			.CELL_IDX(g)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctrl(ctrl),
			.wr_idx(count_q[IDX_W-1:0]),
			.mark_idx(ch_idx[MAX_CITIES]),
			.wr_label(city_label),
			.wr_x(coord_x),
			.wr_y(coord_y),
			.cur_x(cur_x_q),
			.cur_y(cur_y_q),
			.in_valid(ch_valid[g]),
			.in_dist(ch_dist[g]),
			.in_idx(ch_idx[g]),
			.in_label(ch_label[g]),
			.in_x(ch_x[g]),
			.in_y(ch_y[g]),
			.out_valid(ch_valid[g+1]),
			.out_dist(ch_dist[g+1]),
			.out_idx(ch_idx[g+1]),
			.out_label(ch_label[g+1]),
			.out_x(ch_x[g+1]),
			.out_y(ch_y[g+1])
		);
	end

	// first city's coordinates seed the search, so position zero picks it
	always_ff @(posedge clk) begin
		if (ctrl.wr_en && (count_q == '0)) begin
			first_x_q <= coord_x;
			first_y_q <= coord_y;
		end
		if (accept && last_city) begin
			cur_x_q <= (count_q == '0) ? coord_x : first_x_q;
			cur_y_q <= (count_q == '0) ? coord_y : first_y_q;
		end else if (emit) begin
			cur_x_q <= ch_x[MAX_CITIES];
			cur_y_q <= ch_y[MAX_CITIES];
		end
		if (emit) begin
			out_label_q <= ch_label[MAX_CITIES];
			out_pos_q <= pos_q;
			out_end_q <= final_pos;
			out_ovf_q <= dropped_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			pos_q <= '0;
			wait_q <= '0;
			dropped_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit)
				out_valid_q <= 1'b1;
			else if (tour_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (full)
							dropped_q <= 1'b1;
						else
							count_q <= count_q + CNT_W'(1);
						if (last_city) begin
							state_q <= ST_SCAN;
							pos_q <= '0;
							wait_q <= '0;
						end
					end
				end
				ST_SCAN: begin
					if (wait_q == WAIT_W'(WAIT_CYC))
						state_q <= ST_EMIT;
					else
						wait_q <= wait_q + WAIT_W'(1);
				end
				ST_EMIT: begin
					if (emit) begin
						wait_q <= '0;
						if (final_pos) begin
							state_q <= ST_IDLE;
							count_q <= '0;
							dropped_q <= 1'b0;
							pos_q <= '0;
						end else begin
							state_q <= ST_SCAN;
							pos_q <= pos_q + CNT_W'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign tour_valid = out_valid_q;
	assign tour_label = out_label_q;
	assign tour_position = POS_W'(out_pos_q);
	assign tour_end = out_end_q;
	assign overflow = out_ovf_q;

	`NNT_ASSERT(a_emit_has_cand, !(state_q == ST_EMIT) || ch_valid[MAX_CITIES], "no candidate")
	`NNT_ASSERT(a_pos_in_range, (state_q == ST_IDLE) || (pos_q < count_q), "position overrun")
	`NNT_ASSERT_NEXT(a_last_clears, emit && final_pos, (count_q == '0) && city_ready, "set not cleared")
endmodule

// ----- design/nnt_cell.sv -----
// ----------------------------------------------------------------------------
// nnt_cell
// One city slot: holds a city, computes its squared distance to the current
// city and passes the running best candidate on to the next cell.
// ----------------------------------------------------------------------------
module nnt_cell #(
	parameter int COORD_BITS = nnt_pkg::COORD_BITS_DEF,
	parameter int IDX_W = $clog2(nnt_pkg::MAX_CITIES_DEF),
	parameter int CELL_IDX = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  nnt_pkg::cell_ctrl_t ctrl,
	input  logic [IDX_W-1:0] wr_idx,
	input  logic [IDX_W-1:0] mark_idx,
	input  logic [nnt_pkg::LABEL_W-1:0] wr_label,
	input  logic signed [COORD_BITS-1:0] wr_x,
	input  logic signed [COORD_BITS-1:0] wr_y,
	input  logic signed [COORD_BITS-1:0] cur_x,
	input  logic signed [COORD_BITS-1:0] cur_y,
	input  logic in_valid,
	input  logic [2*COORD_BITS+2:0] in_dist,
	input  logic [IDX_W-1:0] in_idx,
	input  logic [nnt_pkg::LABEL_W-1:0] in_label,
	input  logic signed [COORD_BITS-1:0] in_x,
	input  logic signed [COORD_BITS-1:0] in_y,
	output logic out_valid,
	output logic [2*COORD_BITS+2:0] out_dist,
	output logic [IDX_W-1:0] out_idx,
	output logic [nnt_pkg::LABEL_W-1:0] out_label,
	output logic signed [COORD_BITS-1:0] out_x,
	output logic signed [COORD_BITS-1:0] out_y
);
	import nnt_pkg::*;

	localparam int D_W = COORD_BITS + 1;
	localparam int SQ_W = 2 * D_W;
	localparam int DIST_W = SQ_W + 1;
	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	logic signed [COORD_BITS-1:0] x_q, y_q;
	logic [LABEL_W-1:0] label_q;
	logic loaded_q, visited_q;
	logic signed [D_W-1:0] dx, dy;
	logic [D_W-1:0] adx_s1, ady_s1;
	logic [SQ_W-1:0] sqx_s2, sqy_s2;
	logic [DIST_W-1:0] dist_s3;
	logic wr_hit, eligible, take;

	assign wr_hit = ctrl.wr_en && (wr_idx == MY_IDX);

	always_ff @(posedge clk) begin
		if (wr_hit) begin
			x_q <= wr_x;
			y_q <= wr_y;
			label_q <= wr_label;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= 1'b0;
			visited_q <= 1'b0;
		end else if (ctrl.clr) begin
			loaded_q <= 1'b0;
			visited_q <= 1'b0;
		end else begin
			if (wr_hit)
				loaded_q <= 1'b1;
			if (ctrl.mark_en && (mark_idx == MY_IDX))
				visited_q <= 1'b1;
		end
	end

	// distance pipeline: |d| -> squares -> sum
	assign dx = {cur_x[COORD_BITS-1], cur_x} - {x_q[COORD_BITS-1], x_q};
	assign dy = {cur_y[COORD_BITS-1], cur_y} - {y_q[COORD_BITS-1], y_q};

	always_ff @(posedge clk) begin
		adx_s1 <= dx[D_W-1] ? D_W'(-dx) : D_W'(dx);
		ady_s1 <= dy[D_W-1] ? D_W'(-dy) : D_W'(dy);
		sqx_s2 <= SQ_W'(adx_s1) * SQ_W'(adx_s1);
		sqy_s2 <= SQ_W'(ady_s1) * SQ_W'(ady_s1);
		dist_s3 <= DIST_W'(sqx_s2) + DIST_W'(sqy_s2);
	end

	// strict less-than keeps the earlier city on a tie
	assign eligible = loaded_q && !visited_q;
	assign take = eligible && (!in_valid || (dist_s3 < in_dist));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else
			out_valid <= in_valid || eligible;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_dist <= dist_s3;
			out_idx <= MY_IDX;
			out_label <= label_q;
			out_x <= x_q;
			out_y <= y_q;
		end else begin
			out_dist <= in_dist;
			out_idx <= in_idx;
			out_label <= in_label;
			out_x <= in_x;
			out_y <= in_y;
		end
	end
endmodule

// ----- test/nearest_neighbor_tour_top_test.sv -----
// ----------------------------------------------------------------------------
// nearest_neighbor_tour_top_test
// Self-checking bench for the nearest-neighbour tour block: city sets are
// loaded over the city channel and every tour transaction is compared with a
// greedy tour worked out in the bench. A short table of directed sets comes
// first, then random sets under several idling phases.
// ----------------------------------------------------------------------------
module nearest_neighbor_tour_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NCITY = nnt_pkg::MAX_CITIES_DEF;
	localparam int CW = nnt_pkg::COORD_BITS_DEF;
	localparam int LW = nnt_pkg::LABEL_W;
	localparam int PW = nnt_pkg::POS_W;

	typedef struct packed {
		logic [LW-1:0] label;
		logic [PW-1:0] pos;
		logic          tend;
		logic          ovf;
	} stop_t;

	typedef struct {
		logic [LW-1:0] label;
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic          last;
		logic          typed; // single-city set, expected stop typed in
	} city_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic city_valid = 1'b0;
	logic city_ready;
	logic [LW-1:0] city_label = '0;
	logic signed [CW-1:0] coord_x = '0;
	logic signed [CW-1:0] coord_y = '0;
	logic last_city = 1'b0;
	logic tour_valid;
	logic tour_ready = 1'b0;
	logic [LW-1:0] tour_label;
	logic [PW-1:0] tour_position;
	logic tour_end;
	logic overflow;

	nearest_neighbor_tour_top DUT (
		.clk(clk), .arst_n(arst_n),
		.city_valid(city_valid), .city_ready(city_ready),
		.city_label(city_label), .coord_x(coord_x), .coord_y(coord_y),
		.last_city(last_city),
		.tour_valid(tour_valid), .tour_ready(tour_ready),
		.tour_label(tour_label), .tour_position(tour_position),
		.tour_end(tour_end), .overflow(overflow)
	);

	always #5 clk = ~clk;

	// bench copy of the city store
	logic signed [CW-1:0] map_x [NCITY];
	logic signed [CW-1:0] map_y [NCITY];
	logic [LW-1:0] map_label [NCITY];
	int map_count = 0;
	bit map_dropped = 0;

	stop_t tour_q[$];
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_cycles = 0;

	// greedy nearest-neighbour tour; returns number of stops
	function automatic int plan_tour(input city_row_t c, output stop_t stops[NCITY]);
		bit seen [NCITY];
		int n, cur, best_i;
		longint dx, dy, d, best;
		if (map_count < NCITY) begin
			map_label[map_count] = c.label;
			map_x[map_count] = c.x;
			map_y[map_count] = c.y;
			map_count++;
		end else begin
			map_dropped = 1;
		end
		if (!c.last)
			return 0;
		n = map_count;
		foreach (seen[i]) seen[i] = 0;
		cur = 0;
		for (int p = 0; p < n; p++) begin
			if (p > 0) begin
				best_i = -1;
				best = 0;
				for (int i = 0; i < n; i++) begin
					if (seen[i])
						continue;
					dx = longint'(map_x[cur]) - longint'(map_x[i]);
					dy = longint'(map_y[cur]) - longint'(map_y[i]);
					d = dx * dx + dy * dy;
					if (best_i < 0 || d < best) begin
						best = d;
						best_i = i;
					end
				end
				cur = best_i;
			end
			seen[cur] = 1;
			stops[p] = '{map_label[cur], PW'(p), p == n - 1, map_dropped};
		end
		map_count = 0;
		map_dropped = 0;
		return n;
	endfunction

	// drive one city, wait for its transaction, then predict
	task automatic send_city(input city_row_t c);
		stop_t stops[NCITY];
		stop_t one;
		int n;
		if ($urandom_range(99) < send_idle_pct) begin
			city_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		city_valid <= 1'b1;
		city_label <= c.label;
		coord_x <= c.x;
		coord_y <= c.y;
		last_city <= c.last;
		do @(posedge clk); while (!city_ready);
		n = plan_tour(c, stops);
		if (c.typed) begin
			one = '{c.label, '0, 1'b1, 1'b0};
			tour_q.insert(tour_q.size(), one);
		end else begin
			for (int i = 0; i < n; i++) tour_q.insert(tour_q.size(), stops[i]);
		end
	endtask

	function automatic logic [CW-1:0] rand_coord();
		case ($urandom_range(3))
			0: return CW'($urandom);
			1: return CW'($urandom_range(8)) << 8; // coarse grid: many ties
			2: return '1 - CW'($urandom_range(3));
			default: return CW'($urandom_range(CW'(1) << (CW - 1), 0)) ^ CW'($urandom);
		endcase
	endfunction

	task automatic send_random_set(input int n);
		city_row_t c;
		for (int i = 0; i < n; i++) begin
			c.label = LW'($urandom);
			c.x = rand_coord();
			c.y = rand_coord();
			c.last = (i == n - 1);
			c.typed = 0;
			send_city(c);
		end
	endtask

	// receiver: ready driving and tour checking
	always @(posedge clk) begin
		stop_t got, want;
		if (arst_n && tour_valid && tour_ready) begin
			got = '{tour_label, tour_position, tour_end, overflow};
			if (tour_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected tour transaction %p", got);
			end else begin
				want = tour_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("tour mismatch: expected %p, got %p", want, got);
				end
			end
		end
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			tour_ready <= 1'b0;
		end else begin
			tour_ready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	city_row_t directed [] = '{
		'{16'hFFFF, 20'h7FFFF, 20'h80000, 1'b1, 1'b1},
		'{16'h0000, 20'h80000, 20'h7FFFF, 1'b1, 1'b1},
		'{16'h5555, 20'h55555, 20'hAAAAA, 1'b1, 1'b1},
		'{16'hAAAA, 20'hAAAAA, 20'h55555, 1'b1, 1'b1},
		// opposite corners: widest distances
		'{16'h0001, 20'h00000, 20'h00000, 1'b0, 1'b0},
		'{16'h0002, 20'h80000, 20'h80000, 1'b0, 1'b0},
		'{16'h0003, 20'h7FFFF, 20'h7FFFF, 1'b1, 1'b0},
		// equal distances: earliest loaded wins
		'{16'h0010, 20'h00000, 20'h00000, 1'b0, 1'b0},
		'{16'h0011, 20'h00100, 20'h00000, 1'b0, 1'b0},
		'{16'h0012, 20'hFFF00, 20'h00000, 1'b0, 1'b0},
		'{16'h0013, 20'h00000, 20'h00100, 1'b1, 1'b0},
		// coincident cities
		'{16'h0020, 20'h00005, 20'h00005, 1'b0, 1'b0},
		'{16'h0021, 20'h00005, 20'h00005, 1'b0, 1'b0},
		'{16'h0022, 20'h00005, 20'h00005, 1'b1, 1'b0}
	};

	initial begin
		int sent, wait_cnt;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i]) send_city(directed[i]);
		sent = directed.size();

		// full store plus two dropped cities, with a long output hold-off
		hold_cycles = 400;
		send_random_set(NCITY + 2);
		sent += NCITY + 2;

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 68; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 68; end
				default: begin send_idle_pct = 16; recv_stall_pct = 16; end
			endcase
			for (int k = 0; k < 8; k++) begin
				int n;
				n = $urandom_range(1, 6);
				send_random_set(n);
				sent += n;
			end
			// sender pauses until every tour transaction is back
			city_valid <= 1'b0;
			while (tour_q.size() != 0) @(posedge clk);
		end
		while (sent < 220) begin
			int n;
			n = $urandom_range(1, 8);
			send_random_set(n);
			sent += n;
		end
		city_valid <= 1'b0;

		wait_cnt = 0;
		while (tour_q.size() != 0 && wait_cnt < 200000) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (200) @(posedge clk);
		if (mismatches == 0 && tour_q.size() == 0)
			$display("** nearest_neighbor_tour_top: PASSED **");
		else
			$display("** nearest_neighbor_tour_top: FAILED **");
		$finish;
	end

	initial begin
		#10ms;
		$display("** nearest_neighbor_tour_top: FAILED **");
		$finish;
	end
endmodule

// ----- files.f -----
+incdir+design
design/nnt_pkg.sv
design/nnt_cell.sv
design/nearest_neighbor_tour_top.sv
test/nearest_neighbor_tour_top_test.sv
